/* rtl/i2p_pkg.sv */
// Shared types, codes and helpers for the infix-to-postfix converter.
package i2p_pkg;

  localparam int OP_W = 3;

  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_PLUS   = 3'd1;
  localparam logic [2:0] KIND_MINUS  = 3'd2;
  localparam logic [2:0] KIND_TIMES  = 3'd3;
  localparam logic [2:0] KIND_DIVIDE = 3'd4;
  localparam logic [2:0] KIND_OPEN   = 3'd5;
  localparam logic [2:0] KIND_CLOSE  = 3'd6;
  localparam logic [2:0] KIND_END    = 3'd7;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] number_tag;
  } token_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [15:0] out_tag;
    logic [1:0]  error_code;
    logic        run_last;
  } result_t;

  function automatic logic [1:0] prec_of(input logic [2:0] kind);
    logic [1:0] p;
    p = 2'd0;
    if (kind == KIND_PLUS || kind == KIND_MINUS) p = 2'd1;
    if (kind == KIND_TIMES || kind == KIND_DIVIDE) p = 2'd2;
    return p;
  endfunction

  function automatic logic is_operator(input logic [2:0] kind);
    return (kind == KIND_PLUS) || (kind == KIND_MINUS) ||
           (kind == KIND_TIMES) || (kind == KIND_DIVIDE);
  endfunction

endpackage

/* rtl/infix_to_postfix_converter_core.sv */
// Infix-to-postfix converter top level: sequencer around the operator stack memory.
//
//   channel | dir | handshake                  | word
//   token   | in  | token_valid / token_stall  | token_t  (token_kind, number_tag)
//   result  | out | result_valid / result_stall| result_t (out_kind, out_tag, error_code, run_last)
//
// A number goes through the finish state. Open, an operator on an empty stack, close or
// end on an empty stack, or a discarded token is handled in idle. Else the top is read,
// each popped entry takes a step (an open dropped by close or met at end counts), as does
// a push above an entry, and finish sends the last word or idles; one read port, one pop.
// rst clears the stack count, discard flag and handshake state; stack contents need none.
// A stalled result holds the sequencer; token_stall is high while a token is in work.
module infix_to_postfix_converter_core import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    token_valid,
  output logic    token_stall,
  input  token_t  token,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            discard, discard_next;
  logic [2:0]      kind, kind_next;
  logic            pend_valid, pend_valid_next;
  result_t         pend, pend_next;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [OP_W-1:0] mem_wdata, top;

  logic            out_load, emit_ok;
  result_t         out_din;

  logic            prod;
  result_t         prod_word;
  logic            can_go;
  logic [CW-1:0]   cnt_m1, cnt_m2;

  assign cnt_m1 = count - ONE_C;
  assign cnt_m2 = count - CW'(2);
  assign can_go = !pend_valid || emit_ok;
  assign token_stall = (state != S_IDLE);

  i2p_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(top)
  );

  i2p_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .din         (out_din),
    .emit_ok     (emit_ok),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    discard_next    = discard;
    kind_next       = kind;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = kind;
    mem_re          = 1'b0;
    mem_raddr       = cnt_m1[AW-1:0];
    out_load        = 1'b0;
    out_din         = pend;
    out_din.run_last = 1'b0;
    prod            = 1'b0;
    prod_word       = '0;

    unique case (state)
      S_IDLE: begin
        if (token_valid) begin
          kind_next = token.token_kind;
          if (discard) begin
            if (token.token_kind == KIND_END) begin
              discard_next = 1'b0;
              count_next   = '0;
            end
          end else if (token.token_kind == KIND_NUMBER) begin
            prod                = 1'b1;
            prod_word.out_kind  = KIND_NUMBER;
            prod_word.out_tag   = token.number_tag;
            state_next          = S_FIN;
          end else if (token.token_kind == KIND_OPEN ||
                       (is_operator(token.token_kind) && count == '0)) begin
            if (count == DEPTH_C) begin
              prod                 = 1'b1;
              prod_word.out_kind   = KIND_ERROR;
              prod_word.error_code = ERR_OVERFLOW;
              count_next           = '0;
              discard_next         = 1'b1;
              state_next           = S_FIN;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = token.token_kind;
              count_next = count + ONE_C;
            end
          end else if (count != '0) begin
            mem_re     = 1'b1;
            state_next = S_POP;
          end
        end
      end

      S_POP: begin
        if (can_go) begin
          if (is_operator(kind)) begin
            if (top == KIND_OPEN || prec_of(top) < prec_of(kind)) begin
              if (count == DEPTH_C) begin
                prod                 = 1'b1;
                prod_word.out_kind   = KIND_ERROR;
                prod_word.error_code = ERR_OVERFLOW;
                count_next           = '0;
                discard_next         = 1'b1;
              end else begin
                mem_we     = 1'b1;
                count_next = count + ONE_C;
              end
              state_next = S_FIN;
            end else begin
              prod               = 1'b1;
              prod_word.out_kind = top;
              if (count == ONE_C) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                count_next = ONE_C;
                state_next = S_FIN;
              end else begin
                count_next = cnt_m1;
                mem_re     = 1'b1;
                mem_raddr  = cnt_m2[AW-1:0];
              end
            end
          end else if (kind == KIND_CLOSE) begin
            count_next = cnt_m1;
            if (top == KIND_OPEN) begin
              state_next = S_FIN;
            end else begin
              prod               = 1'b1;
              prod_word.out_kind = top;
              if (count == ONE_C) begin
                state_next = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m2[AW-1:0];
              end
            end
          end else begin
            prod = 1'b1;
            if (top == KIND_OPEN) begin
              prod_word.out_kind   = KIND_ERROR;
              prod_word.error_code = ERR_UNMATCHED;
              count_next           = '0;
              state_next           = S_FIN;
            end else begin
              prod_word.out_kind = top;
              count_next         = cnt_m1;
              if (count == ONE_C) begin
                state_next = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m2[AW-1:0];
              end
            end
          end
        end
      end

      S_FIN: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (emit_ok) begin
          out_load         = 1'b1;
          out_din.run_last = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (prod) begin
      out_load        = pend_valid;
      pend_next       = prod_word;
      pend_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      discard    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      discard    <= discard_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    pend <= pend_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || !result_stall))
    else $error("result word overwritten while stalled");

  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    discard |-> count == '0)
    else $error("stack not empty while discarding");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending word left behind at idle");

endmodule

/* rtl/i2p_stack_mem.sv */
// Operator stack storage: one write port, one registered read port.
module i2p_stack_mem import i2p_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [OP_W-1:0] wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output logic [OP_W-1:0] rdata
);

  logic [OP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* rtl/i2p_out_reg.sv */
// Output register for result words.
module i2p_out_reg import i2p_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    emit_ok,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  assign emit_ok = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= din;
  end

endmodule
